[design/servo_bus_status_packet_parser_macros.svh]
// Assertion macros shared by the status packet parser modules.
`ifndef SERVO_BUS_STATUS_PACKET_PARSER_MACROS_SVH
`define SERVO_BUS_STATUS_PACKET_PARSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBSP_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SBSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/sbsp_pkg.sv]
// Types, constants and codes shared by the status packet parser modules.
package sbsp_pkg;

	localparam int BODY_CAP   = 1024;
	localparam int MAX_PARAMS = 16;
	localparam int MAX_LENGTH = 64;

	localparam int CNT_W   = $clog2(BODY_CAP + 1);
	localparam int PIDX_W  = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
	localparam int SHOWN_W = $clog2(MAX_PARAMS + 1);

	// Input actions.
	localparam logic [1:0] ACT_BYTE    = 2'd0;
	localparam logic [1:0] ACT_TIMEOUT = 2'd1;
	localparam logic [1:0] ACT_RESTART = 2'd2;

	// Header hunt progress once FF FF FD has been seen.
	localparam logic [1:0] HDR_DONE = 2'd3;
	localparam logic [7:0] HDR_FF   = 8'hFF;
	localparam logic [7:0] HDR_FD   = 8'hFD;

	// Body byte positions.
	localparam logic [CNT_W-1:0] BIDX_ID     = CNT_W'(1);
	localparam logic [CNT_W-1:0] BIDX_LEN_LO = CNT_W'(2);
	localparam logic [CNT_W-1:0] BIDX_LEN_HI = CNT_W'(3);
	localparam logic [CNT_W-1:0] BIDX_STATUS = CNT_W'(5);
	localparam logic [CNT_W-1:0] BIDX_PARAM0 = CNT_W'(6);
	localparam logic [CNT_W-1:0] BIDX_PEND   = CNT_W'(6 + MAX_PARAMS);
	localparam logic [CNT_W-1:0] BODY_FULL   = CNT_W'(BODY_CAP);

	localparam logic [15:0] LEN_UNKNOWN = 16'd1024;

	// Report kinds.
	localparam logic [1:0] RPT_TIMEOUT  = 2'd0;
	localparam logic [1:0] RPT_MISMATCH = 2'd1;
	localparam logic [1:0] RPT_LONG     = 2'd2;
	localparam logic [1:0] RPT_DATA     = 2'd3;

	typedef struct packed {
		logic                start;
		logic [1:0]          kind;
		logic [7:0]          status;
		logic [5:0]          count;
		logic [SHOWN_W-1:0]  shown;
	} rpt_req_t;

	typedef struct packed {
		logic               en;
		logic [PIDX_W-1:0]  addr;
		logic [7:0]         data;
	} mem_wr_t;

	typedef struct packed {
		logic               en;
		logic [PIDX_W-1:0]  addr;
	} mem_rd_t;

endpackage

[design/servo_bus_status_packet_parser.sv]
// Top level of the servo bus status packet parser.
//
// The parser takes one transfer per cycle on the input channel: a received byte, a receive
// timeout or a restart. It hunts for the header FF FF FD (a surplus FF keeps the progress made),
// then numbers the body bytes from zero, capturing the responder ID (body byte 1), the 16-bit
// length (bytes 2 and 3, low byte first), the device status byte (byte 5) and up to sixteen
// parameter bytes (from byte 6) in a small synchronous parameter memory. The packet ends at body
// byte length+3, on a timeout, or on the first byte that arrives with 1024 body bytes already
// held; that byte is dropped. The CRC is not checked. Each packet end yields a report on the
// result channel: a single timed-out result when no body byte came, a single ID mismatch
// result when the ID differs from device_id, a single empty result when the length exceeds 64,
// otherwise the status byte and the parameter count (length-4, zero below four) on either one
// result with no parameter or on a run of min(count,16) parameter results, last marking the end.
// Parameters never received read as zero. Once a transfer ends a packet, in_stall is raised
// from the next cycle until the final result of the report has been transferred. A single
// result is loaded straight from the request and then waits for the sink; a parameter run goes
// through a memory read, an output load and a transfer for each result, since the parameter
// memory has a registered read port. The memory needs no clearing pass: per-entry valid bits
// are cleared by a restart or by the end of a report, and the input stall keeps writes and
// report reads from ever overlapping. device_id is written through cfg_wr_en and cfg_wr_data
// and must only be changed while the block is idle.
`include "servo_bus_status_packet_parser_macros.svh"

module servo_bus_status_packet_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        timed_out,
	output logic        id_mismatch,
	output logic [7:0]  status_flags,
	output logic [5:0]  param_count,
	output logic        param_valid,
	output logic [3:0]  param_index,
	output logic [7:0]  param_byte,
	output logic        last
);
	import sbsp_pkg::*;

	logic [7:0] device_id_r_q;
	logic       in_acc;
	logic       busy;
	logic       restart_clr;
	logic       report_clr;
	logic [7:0] rd_data;
	mem_wr_t    wr;
	mem_rd_t    rd;
	rpt_req_t   req;

	// The expected responder ID register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_id_r_q <= 8'd0;
		end else if (cfg_wr_en) begin
			device_id_r_q <= cfg_wr_data;
		end
	end

	// Input transfers are refused for the whole of a report.
	assign in_stall = busy;
	assign in_acc   = in_valid && !in_stall;

	sbsp_rx_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_acc      (in_acc),
		.action      (action),
		.rx_byte     (rx_byte),
		.device_id   (device_id_r_q),
		.wr          (wr),
		.restart_clr (restart_clr),
		.req         (req)
	);

	sbsp_param_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd      (rd),
		.clr     (restart_clr || report_clr),
		.rd_data (rd_data)
	);

	sbsp_report u_report (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.rd           (rd),
		.rd_data      (rd_data),
		.mem_clr      (report_clr),
		.busy         (busy),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.timed_out    (timed_out),
		.id_mismatch  (id_mismatch),
		.status_flags (status_flags),
		.param_count  (param_count),
		.param_valid  (param_valid),
		.param_index  (param_index),
		.param_byte   (param_byte),
		.last         (last)
	);

	`SBSP_ASSERT_HOLDS(a_cfg_idle, clk, arst_n, cfg_wr_en, !busy, "device_id written mid-report")
	`SBSP_ASSERT_NEXT(a_out_held, clk, arst_n, out_valid && out_stall, out_valid, "result withdrawn")
	`SBSP_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(param_byte), "byte moved")
	`SBSP_ASSERT_NEXT(a_in_free, clk, arst_n, out_valid && !out_stall && last, !in_stall, "input held")

endmodule

[design/sbsp_param_store.sv]
// Parameter byte memory with one write port, one registered read port and per-entry valid bits.
module sbsp_param_store (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sbsp_pkg::mem_wr_t     wr,
	input  sbsp_pkg::mem_rd_t     rd,
	input  logic                  clr,
	output logic [7:0]            rd_data
);
	import sbsp_pkg::*;

	logic [7:0]            mem [MAX_PARAMS];
	logic [MAX_PARAMS-1:0] vld_q;
	logic [7:0]            rd_mem_q;
	logic                  rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rd_mem_q <= mem[rd.addr];
		end
	end

	// Entries never written since the last clear read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (clr) begin
				vld_q <= '0;
			end else if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			if (rd.en) begin
				rd_vld_q <= vld_q[rd.addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_mem_q : 8'd0;

endmodule

[design/sbsp_rx_parser.sv]
// Header hunt and body capture; raises a report request at the end of each packet.
module sbsp_rx_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_acc,
	input  logic [1:0]            action,
	input  logic [7:0]            rx_byte,
	input  logic [7:0]            device_id,
	output sbsp_pkg::mem_wr_t     wr,
	output logic                  restart_clr,
	output sbsp_pkg::rpt_req_t    req
);
	import sbsp_pkg::*;

	logic [1:0]       hdr_q, hdr_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [15:0]      len_q, len_d;
	logic [7:0]       pid_q, pid_d;
	logic [7:0]       stat_q, stat_d;
	logic             end_pkt;
	logic             restart;
	logic [5:0]       count;

	always_comb begin
		hdr_d   = hdr_q;
		cnt_d   = cnt_q;
		len_d   = len_q;
		pid_d   = pid_q;
		stat_d  = stat_q;
		wr      = '0;
		end_pkt = 1'b0;
		restart = 1'b0;
		if (in_acc) begin
			unique case (action)
				ACT_BYTE: begin
					if (hdr_q != HDR_DONE) begin
						if (rx_byte == ((hdr_q == 2'd2) ? HDR_FD : HDR_FF)) begin
							hdr_d = hdr_q + 2'd1;
						end else if (rx_byte != HDR_FF) begin
							hdr_d = 2'd0;
						end
					end else if (cnt_q >= BODY_FULL) begin
						// Body full: the byte is dropped and the packet ends.
						end_pkt = 1'b1;
					end else begin
						priority if (cnt_q == BIDX_ID) begin
							pid_d = rx_byte;
						end else if (cnt_q == BIDX_LEN_LO) begin
							len_d = {len_q[15:8], rx_byte};
						end else if (cnt_q == BIDX_LEN_HI) begin
							len_d = {rx_byte, len_q[7:0]};
						end else if (cnt_q == BIDX_STATUS) begin
							stat_d = rx_byte;
						end else if (cnt_q >= BIDX_PARAM0 && cnt_q < BIDX_PEND) begin
							wr.en   = 1'b1;
							wr.addr = PIDX_W'(cnt_q - BIDX_PARAM0);
							wr.data = rx_byte;
						end else begin
						end
						cnt_d = cnt_q + CNT_W'(1);
						if (cnt_q != BIDX_LEN_HI && 17'(cnt_q) == 17'(len_d) + 17'd3) begin
							end_pkt = 1'b1;
						end
					end
				end
				ACT_TIMEOUT: end_pkt = 1'b1;
				ACT_RESTART: restart = 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q  <= 2'd0;
			cnt_q  <= '0;
			len_q  <= LEN_UNKNOWN;
			pid_q  <= 8'd0;
			stat_q <= 8'd0;
		end else if (end_pkt || restart) begin
			hdr_q  <= 2'd0;
			cnt_q  <= '0;
			len_q  <= LEN_UNKNOWN;
			pid_q  <= 8'd0;
			stat_q <= 8'd0;
		end else begin
			hdr_q  <= hdr_d;
			cnt_q  <= cnt_d;
			len_q  <= len_d;
			pid_q  <= pid_d;
			stat_q <= stat_d;
		end
	end

	assign count = (len_d < 16'd4) ? 6'd0 : 6'(len_d - 16'd4);

	always_comb begin
		req.start  = end_pkt;
		req.status = stat_d;
		req.count  = count;
		req.shown  = ({1'b0, count} < 7'(MAX_PARAMS)) ? SHOWN_W'(count) : SHOWN_W'(MAX_PARAMS);
		priority if (cnt_d == '0) begin
			req.kind = RPT_TIMEOUT;
		end else if (pid_d != device_id) begin
			req.kind = RPT_MISMATCH;
		end else if (len_d > 16'(MAX_LENGTH)) begin
			req.kind = RPT_LONG;
		end else begin
			req.kind = RPT_DATA;
		end
	end

	assign restart_clr = restart;

endmodule

[design/sbsp_report.sv]
// Report sequencer: reads stored parameters and drives the registered result channel.
`include "servo_bus_status_packet_parser_macros.svh"

module sbsp_report (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sbsp_pkg::rpt_req_t    req,
	output sbsp_pkg::mem_rd_t     rd,
	input  logic [7:0]            rd_data,
	output logic                  mem_clr,
	output logic                  busy,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  timed_out,
	output logic                  id_mismatch,
	output logic [7:0]            status_flags,
	output logic [5:0]            param_count,
	output logic                  param_valid,
	output logic [3:0]            param_index,
	output logic [7:0]            param_byte,
	output logic                  last
);
	import sbsp_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_LOAD = 2'd2;
	localparam logic [1:0] ST_HOLD = 2'd3;

	logic [1:0]         state_q;
	logic [1:0]         kind_q;
	logic [7:0]         status_q;
	logic [5:0]         count_q;
	logic [SHOWN_W-1:0] shown_q;
	logic [PIDX_W-1:0]  idx_q;
	logic               out_valid_q;
	logic               timed_out_q;
	logic               id_mismatch_q;
	logic [7:0]         status_flags_q;
	logic [5:0]         param_count_q;
	logic               param_valid_q;
	logic [3:0]         param_index_q;
	logic [7:0]         param_byte_q;
	logic               last_q;
	logic               out_acc;
	logic               single;

	assign out_acc = out_valid_q && !out_stall;
	assign single  = (req.kind != RPT_DATA) || (req.shown == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req.start) begin
						idx_q <= '0;
						if (single) begin
							out_valid_q <= 1'b1;
							state_q     <= ST_HOLD;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: state_q <= ST_LOAD;
				ST_LOAD: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_HOLD;
				end
				ST_HOLD: begin
					if (out_acc) begin
						out_valid_q <= 1'b0;
						if (last_q) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + PIDX_W'(1);
							state_q <= ST_READ;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Request snapshot and result payload registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.start) begin
			kind_q         <= req.kind;
			status_q       <= req.status;
			count_q        <= req.count;
			shown_q        <= req.shown;
			timed_out_q    <= (req.kind == RPT_TIMEOUT);
			id_mismatch_q  <= (req.kind == RPT_MISMATCH);
			status_flags_q <= (req.kind == RPT_DATA) ? req.status : 8'd0;
			param_count_q  <= (req.kind == RPT_DATA) ? req.count : 6'd0;
			param_valid_q  <= 1'b0;
			param_index_q  <= 4'd0;
			param_byte_q   <= 8'd0;
			last_q         <= 1'b1;
		end else if (state_q == ST_LOAD) begin
			timed_out_q    <= 1'b0;
			id_mismatch_q  <= 1'b0;
			status_flags_q <= status_q;
			param_count_q  <= count_q;
			param_valid_q  <= 1'b1;
			param_index_q  <= 4'(idx_q);
			param_byte_q   <= rd_data;
			last_q         <= (SHOWN_W'(idx_q) + SHOWN_W'(1) == shown_q);
		end
	end

	assign rd.en   = (state_q == ST_READ);
	assign rd.addr = idx_q;

	// The store is cleared once the final result of the report is taken.
	assign mem_clr = (state_q == ST_HOLD) && out_acc && last_q;
	assign busy    = (state_q != ST_IDLE);

	assign out_valid    = out_valid_q;
	assign timed_out    = timed_out_q;
	assign id_mismatch  = id_mismatch_q;
	assign status_flags = status_flags_q;
	assign param_count  = param_count_q;
	assign param_valid  = param_valid_q;
	assign param_index  = param_index_q;
	assign param_byte   = param_byte_q;
	assign last         = last_q;

	`SBSP_ASSERT_HOLDS(a_idle_no_result, clk, arst_n, state_q == ST_IDLE, !out_valid_q, "result pending while idle")
	`SBSP_ASSERT_HOLDS(a_start_only_idle, clk, arst_n, req.start, state_q == ST_IDLE, "report requested while busy")
	`SBSP_ASSERT_NEXT(a_last_frees, clk, arst_n, out_acc && last_q, state_q == ST_IDLE && !out_valid_q, "sequencer did not return to idle after final result")
	`SBSP_ASSERT_HOLDS(a_kind_known, clk, arst_n, out_valid_q && param_valid_q, kind_q == RPT_DATA, "parameter result outside a data report")

endmodule

[bench/tb.sv]
// Self-checking testbench for the servo bus status packet parser.
`timescale 1ns / 100ps

module tb;
	import sbsp_pkg::*;

	// The input channel also carries a fourth action code that the parser must ignore.
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	// Cycles allowed after the last report before the block counts as idle again.
	localparam int DRAIN_CYCLES = 16;

	// One result transfer, field for field as it leaves the parser.
	typedef struct packed {
		logic       timed_out;
		logic       id_mismatch;
		logic [7:0] status_flags;
		logic [5:0] param_count;
		logic       param_valid;
		logic [3:0] param_index;
		logic [7:0] param_byte;
		logic       last;
	} parser_result_t;

	// One row of the directed table: an input transfer and, where it is obvious, its report.
	typedef struct packed {
		logic [1:0]     act;
		logic [7:0]     data;
		logic           typed;
		parser_result_t result;
	} stimulus_row_t;

	localparam parser_result_t RES_TIMED_OUT = '{timed_out: 1'b1, last: 1'b1, default: '0};
	localparam parser_result_t RES_ID_MISMATCH = '{id_mismatch: 1'b1, last: 1'b1, default: '0};
	localparam parser_result_t RES_STATUS_ONLY =
		'{status_flags: 8'hFF, last: 1'b1, default: '0};

	// The directed part runs with device_id at its reset value of zero. It covers a timeout
	// straight after reset, the ignored action, a header with a surplus FF, a restart that
	// must throw away a packet already under way, a short packet that ends on an all-ones
	// status byte with nothing to show, and an ID of all ones cut short by a timeout.
	localparam stimulus_row_t DIRECTED_ROWS [25] = '{
		'{ACT_TIMEOUT, 8'h00, 1'b1, RES_TIMED_OUT},
		'{ACT_UNUSED,  8'hFF, 1'b0, '0},
		'{ACT_BYTE,    HDR_FF, 1'b0, '0},
		'{ACT_BYTE,    HDR_FF, 1'b0, '0},
		'{ACT_BYTE,    HDR_FF, 1'b0, '0},
		'{ACT_BYTE,    HDR_FD, 1'b0, '0},
		'{ACT_BYTE,    8'h00, 1'b0, '0},
		'{ACT_BYTE,    8'hFF, 1'b0, '0},
		'{ACT_RESTART, 8'h00, 1'b0, '0},
		'{ACT_BYTE,    HDR_FF, 1'b0, '0},
		'{ACT_BYTE,    HDR_FF, 1'b0, '0},
		'{ACT_BYTE,    HDR_FD, 1'b0, '0},
		'{ACT_BYTE,    8'h00, 1'b0, '0},
		'{ACT_BYTE,    8'h00, 1'b0, '0},
		'{ACT_BYTE,    8'h02, 1'b0, '0},
		'{ACT_BYTE,    8'h00, 1'b0, '0},
		'{ACT_BYTE,    8'h01, 1'b0, '0},
		'{ACT_BYTE,    8'hFF, 1'b1, RES_STATUS_ONLY},
		'{ACT_BYTE,    HDR_FF, 1'b0, '0},
		'{ACT_BYTE,    HDR_FF, 1'b0, '0},
		'{ACT_BYTE,    HDR_FD, 1'b0, '0},
		'{ACT_BYTE,    8'h00, 1'b0, '0},
		'{ACT_BYTE,    8'hFF, 1'b0, '0},
		'{ACT_BYTE,    8'h00, 1'b0, '0},
		'{ACT_TIMEOUT, 8'h00, 1'b1, RES_ID_MISMATCH}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_wr_en = 1'b0;
	logic [7:0] cfg_wr_data = 8'h00;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] action = ACT_BYTE;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       timed_out;
	logic       id_mismatch;
	logic [7:0] status_flags;
	logic [5:0] param_count;
	logic       param_valid;
	logic [3:0] param_index;
	logic [7:0] param_byte;
	logic       last;

	// Our own copy of the parser state and of device_id.
	logic [1:0]  hunt_stage;
	int          body_bytes;
	logic [15:0] pkt_length;
	logic [7:0]  pkt_id;
	logic [7:0]  pkt_status;
	logic [7:0]  param_bytes [MAX_PARAMS];
	logic [7:0]  responder_id;

	// Reports still to arrive, oldest first, and those caused by the latest transfer.
	parser_result_t pending_reports [$];
	parser_result_t step_reports [$];

	int error_count = 0;
	int items_sent = 0;
	int reports_due = 0;
	int burst_left = 0;

	servo_bus_status_packet_parser u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.timed_out    (timed_out),
		.id_mismatch  (id_mismatch),
		.status_flags (status_flags),
		.param_count  (param_count),
		.param_valid  (param_valid),
		.param_index  (param_index),
		.param_byte   (param_byte),
		.last         (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// A hard ceiling on the run, so that a hung simulation still ends and reports a failure.
	initial begin : watchdog
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// ------------------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------------------

	// After a restart and after every report the receiver hunts for a fresh header, with
	// nothing of the old packet left behind.
	function automatic void rearm_parser_model();
		hunt_stage = 2'd0;
		body_bytes = 0;
		pkt_length = LEN_UNKNOWN;
		pkt_id     = 8'h00;
		pkt_status = 8'h00;
		foreach (param_bytes[i])
			param_bytes[i] = 8'h00;
	endfunction

	// Builds the report for the packet just ended. The checks run in order of precedence: no
	// body at all, then a foreign ID, then a length too long to report on.
	function automatic void close_packet_report();
		parser_result_t res;
		int             count;
		int             shown;
		res      = '0;
		res.last = 1'b1;
		shown    = 0;
		if (body_bytes == 0) begin
			res.timed_out = 1'b1;
		end else if (pkt_id != responder_id) begin
			res.id_mismatch = 1'b1;
		end else if (pkt_length <= MAX_LENGTH) begin
			count = (pkt_length < 16'd4) ? 0 : int'(pkt_length) - 4;
			shown = (count < MAX_PARAMS) ? count : MAX_PARAMS;
			res.status_flags = pkt_status;
			res.param_count  = 6'(count);
			for (int i = 0; i < shown; i++) begin
				res.param_valid = 1'b1;
				res.param_index = 4'(i);
				res.param_byte  = param_bytes[i];
				res.last        = (i == shown - 1);
				step_reports.push_back(res);
			end
		end
		if (shown == 0)
			step_reports.push_back(res);
		rearm_parser_model();
	endfunction

	// Advances the model by one accepted transfer and leaves its reports in step_reports.
	function automatic void predict_parser_step(input logic [1:0] act, input logic [7:0] data);
		int pos;
		step_reports.delete();
		case (act)
			ACT_TIMEOUT: begin
				close_packet_report();
			end
			ACT_RESTART: begin
				rearm_parser_model();
			end
			ACT_BYTE: begin
				if (hunt_stage != HDR_DONE) begin
					// A surplus FF neither advances nor loses the progress made so far.
					if (data == ((hunt_stage == HDR_DONE - 2'd1) ? HDR_FD : HDR_FF))
						hunt_stage = hunt_stage + 2'd1;
					else if (data != HDR_FF)
						hunt_stage = 2'd0;
				end else if (body_bytes >= BODY_CAP) begin
					// The body is full: this byte ends the packet and is dropped.
					close_packet_report();
				end else begin
					pos = body_bytes;
					if (pos == BIDX_ID)
						pkt_id = data;
					else if (pos == BIDX_LEN_LO)
						pkt_length[7:0] = data;
					else if (pos == BIDX_LEN_HI)
						pkt_length[15:8] = data;
					else if (pos == BIDX_STATUS)
						pkt_status = data;
					else if (pos >= BIDX_PARAM0 && pos < BIDX_PEND)
						param_bytes[pos - BIDX_PARAM0] = data;
					body_bytes++;
					// The end test is skipped on the high length byte, so a zero length runs
					// on until the body cap.
					if (pos != BIDX_LEN_HI && pos == int'(pkt_length) + 3)
						close_packet_report();
				end
			end
			default: begin
			end
		endcase
	endfunction

	// ------------------------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------------------------

	// Offers one transfer and waits until the parser takes it. The sender works in bursts of
	// random length; between bursts it drops valid and scribbles on the payload, which the parser
	// must not look at. About a quarter of the bursts follow on with no gap at all.
	task automatic send_item(input logic [1:0] act, input logic [7:0] data,
			input logic typed = 1'b0, input parser_result_t typed_result = '0);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				action   <= 2'($urandom);
				rx_byte  <= 8'($urandom);
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		action   <= act;
		rx_byte  <= data;
		do @(posedge clk); while (in_stall);
		predict_parser_step(act, data);
		if (typed) begin
			pending_reports.push_back(typed_result);
			reports_due++;
		end else begin
			foreach (step_reports[i])
				pending_reports.push_back(step_reports[i]);
			reports_due += step_reports.size();
		end
		if (act != ACT_UNUSED)
			items_sent++;
	endtask

	// Drops valid and waits until every report has come back and the parser has settled.
	task automatic wait_until_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_device_id(input logic [7:0] id);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= id;
		@(negedge clk);
		cfg_wr_en    <= 1'b0;
		responder_id = id;
	endtask

	// Sends one packet with random content. Most are well formed, sometimes behind a little
	// line noise or with surplus FFs in the header, and about one in five is cut short by a
	// timeout or a restart. The rest is bare timeouts and noise that a timeout then closes.
	task automatic send_random_packet();
		int          shape;
		int          pos;
		int          cut_at;
		logic [1:0]  cut_action;
		logic [15:0] length_field;
		logic [7:0]  id_field;
		logic [7:0]  body_byte;
		shape = $urandom_range(0, 99);
		if (shape < 5) begin
			send_item(ACT_TIMEOUT, 8'($urandom));
			return;
		end
		if (shape < 15) begin
			repeat ($urandom_range(1, 8)) begin
				case ($urandom_range(0, 7))
					0: send_item(ACT_UNUSED, 8'($urandom));
					1: send_item(ACT_RESTART, 8'($urandom));
					2, 3: send_item(ACT_BYTE, HDR_FF);
					4: send_item(ACT_BYTE, HDR_FD);
					default: send_item(ACT_BYTE, 8'($urandom));
				endcase
			end
			send_item(ACT_TIMEOUT, 8'($urandom));
			return;
		end

		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 2)) send_item(ACT_BYTE, 8'($urandom));
		repeat (2 + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0))
			send_item(ACT_BYTE, HDR_FF);
		send_item(ACT_BYTE, HDR_FD);

		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: length_field = 16'($urandom_range(1, 20));
			5, 6: length_field = 16'($urandom_range(21, 63));
			7: length_field = ($urandom_range(0, 1) == 0) ? 16'd64 : 16'd65;
			8: length_field = 16'($urandom_range(66, 90));
			default: length_field = 16'($urandom);
		endcase
		id_field = ($urandom_range(0, 4) != 0) ? responder_id : 8'($urandom);

		// Anything longer than a short body is always cut early to keep the run brief.
		cut_at = -1;
		if (length_field > 16'd90 || $urandom_range(0, 6) == 0)
			cut_at = $urandom_range(0, (length_field > 16'd90) ? 12 : int'(length_field) + 3);
		cut_action = ($urandom_range(0, 3) == 0) ? ACT_RESTART : ACT_TIMEOUT;

		// The model tells us when the packet has ended: it then goes back to the header hunt.
		pos = 0;
		while (hunt_stage == HDR_DONE) begin
			if (pos == BIDX_ID)
				body_byte = id_field;
			else if (pos == BIDX_LEN_LO)
				body_byte = length_field[7:0];
			else if (pos == BIDX_LEN_HI)
				body_byte = length_field[15:8];
			else
				body_byte = 8'($urandom);
			if (pos == cut_at)
				send_item(cut_action, body_byte);
			else
				send_item(ACT_BYTE, body_byte);
			pos++;
		end
	endtask

	// ------------------------------------------------------------------------------------
	// Output side
	// ------------------------------------------------------------------------------------

	// The sink stalls on a pattern that steps in turn through no stall, a coin toss, a fixed
	// rhythm and an occasional stall. Now and then, as soon as a report is on offer, it holds
	// off so that the parser backs up and has to stall its input while the sender keeps
	// offering transfers.
	initial begin : sink_pacing
		int cycle;
		int hold_left;
		int next_hold;
		cycle     = 0;
		hold_left = 0;
		next_hold = 200;
		forever begin
			@(negedge clk);
			cycle++;
			if (hold_left == 0 && out_valid === 1'b1 && cycle >= next_hold) begin
				hold_left = 160;
				next_hold = cycle + 500;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				case ((cycle / 96) % 4)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 1) == 0);
					2: out_stall <= ((cycle % 3) == 0);
					default: out_stall <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%02h, got 0x%02h", name, want, got);
			error_count++;
		end
	endfunction

	// Every result transfer is held against the oldest report still pending.
	always @(posedge clk) begin : report_checker
		parser_result_t want;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (pending_reports.size() == 0) begin
				$error("result transfer with no report pending");
				error_count++;
			end else begin
				want = pending_reports.pop_front();
				check_field("timed_out", 8'(want.timed_out), 8'(timed_out));
				check_field("id_mismatch", 8'(want.id_mismatch), 8'(id_mismatch));
				check_field("status_flags", want.status_flags, status_flags);
				check_field("param_count", 8'(want.param_count), 8'(param_count));
				check_field("param_valid", 8'(want.param_valid), 8'(param_valid));
				check_field("param_index", 8'(want.param_index), 8'(param_index));
				check_field("param_byte", want.param_byte, param_byte);
				check_field("last", 8'(want.last), 8'(last));
			end
		end
	end

	// ------------------------------------------------------------------------------------
	// Sequence of the run
	// ------------------------------------------------------------------------------------

	// Reset, then the directed table at the reset value of device_id, then three random
	// phases with device_id at all ones, at a random value and written back to zero. Each
	// phase ends once the counts kept since the directed part reach seventy transfers and sixteen
	// predicted reports for each phase so far; the register is only rewritten once the parser
	// has drained.
	initial begin : sequencer
		logic [7:0] phase_ids [3];
		phase_ids[0] = 8'hFF;
		phase_ids[1] = 8'($urandom);
		phase_ids[2] = 8'h00;

		rearm_parser_model();
		responder_id = 8'h00;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED_ROWS[i])
			send_item(DIRECTED_ROWS[i].act, DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].typed,
				DIRECTED_ROWS[i].result);
		wait_until_drained();

		items_sent  = 0;
		reports_due = 0;
		for (int phase = 0; phase < 3; phase++) begin
			write_device_id(phase_ids[phase]);
			while (items_sent < 70 * (phase + 1) || reports_due < 16 * (phase + 1))
				send_random_packet();
			wait_until_drained();
		end

		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[sim.f]
+incdir+design
design/sbsp_pkg.sv
design/sbsp_param_store.sv
design/sbsp_rx_parser.sv
design/sbsp_report.sv
design/servo_bus_status_packet_parser.sv
bench/tb.sv
